/* design/pcs_pkg.sv */
// Shared constants and types for the percentile contrast stretch unit.
// No dependencies; used by pcs_point, pcs_div and the top level.
`default_nettype none

package pcs_pkg;

  localparam int unsigned GREY_LEVELS  = 256;
  localparam int unsigned BIN_AW       = 8;
  localparam int unsigned BIN_W        = 23;
  localparam int unsigned PIX_W        = 8;
  localparam int unsigned PT_W         = 9;
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned DIST_W       = 28;
  localparam int unsigned NUM_W        = 16;
  localparam int unsigned DEN_W        = 9;
  localparam int unsigned DIV_CW       = 4;
  localparam int unsigned OUT_W        = 32;

  localparam logic [BIN_W-1:0] MAX_PIXELS   = BIN_W'(4194304);
  localparam logic [PIX_W-1:0] STRETCH_GAIN = PIX_W'(243);
  localparam logic [PIX_W-1:0] PIX_MAX      = PIX_W'(255);
  localparam logic [BIN_AW-1:0] LAST_BIN    = BIN_AW'(GREY_LEVELS - 1);
  localparam logic signed [PT_W-1:0] PT_NONE      = PT_W'(-1);
  localparam logic signed [PT_W-1:0] PT_LO_RESET  = PT_W'(0);
  localparam logic signed [PT_W-1:0] PT_HI_RESET  = PT_W'(255);

  localparam logic CMD_HIST = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  typedef struct packed {
    logic              found_lo;
    logic [BIN_AW-1:0] pt_lo;
    logic              found_hi;
    logic [BIN_AW-1:0] pt_hi;
  } point_res_t;

endpackage

`default_nettype wire

/* design/pcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* design/pcs_point.sv */
// Cumulative-distribution point tracker: takes one bin a cycle and keeps
// the 5% and 95% distance minima. Depends on pcs_pkg.
`default_nettype none

module pcs_point (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [pcs_pkg::BIN_W-1:0]   seen_i,
  input  wire logic                        bin_vld_i,
  input  wire logic [pcs_pkg::BIN_AW-1:0]  bin_idx_i,
  input  wire logic [pcs_pkg::BIN_W-1:0]   bin_cnt_i,
  output pcs_pkg::point_res_t              res_o
);

  logic [pcs_pkg::BIN_W-1:0]  cum_q, cum_d;
  logic [pcs_pkg::DIST_W-1:0] best_lo_q, best_hi_q;
  logic [pcs_pkg::DIST_W-1:0] scaled, tgt_lo, tgt_hi, dist_lo, dist_hi;
  pcs_pkg::point_res_t        res_q;

  function automatic logic [pcs_pkg::DIST_W-1:0] abs_diff(
    input logic [pcs_pkg::DIST_W-1:0] a,
    input logic [pcs_pkg::DIST_W-1:0] b
  );
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign cum_d   = cum_q + bin_cnt_i;
  assign scaled  = (pcs_pkg::DIST_W'(cum_d) << 4) + (pcs_pkg::DIST_W'(cum_d) << 2);
  assign tgt_lo  = pcs_pkg::DIST_W'(seen_i);
  assign tgt_hi  = (pcs_pkg::DIST_W'(seen_i) << 4) + (pcs_pkg::DIST_W'(seen_i) << 1)
                 + pcs_pkg::DIST_W'(seen_i);
  assign dist_lo = abs_diff(scaled, tgt_lo);
  assign dist_hi = abs_diff(scaled, tgt_hi);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q        <= '0;
      res_q        <= '0;
      best_lo_q    <= '0;
      best_hi_q    <= '0;
    end else if (start_i) begin
      cum_q          <= '0;
      res_q.found_lo <= 1'b0;
      res_q.found_hi <= 1'b0;
    end else if (bin_vld_i) begin
      cum_q <= cum_d;
      if (bin_idx_i == '0) begin
        best_lo_q <= dist_lo;
        best_hi_q <= dist_hi;
      end else begin
        if (!res_q.found_lo) begin
          if (best_lo_q >= dist_lo) begin
            best_lo_q <= dist_lo;
          end else begin
            res_q.found_lo <= 1'b1;
            res_q.pt_lo    <= bin_idx_i;
          end
        end
        if (!res_q.found_hi) begin
          if (best_hi_q >= dist_hi) begin
            best_hi_q <= dist_hi;
          end else begin
            res_q.found_hi <= 1'b1;
            res_q.pt_hi    <= bin_idx_i;
          end
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* design/pcs_div.sv */
// Restoring divider, one quotient bit a cycle, for the stretch gain term.
// Depends on pcs_pkg.
`default_nettype none

module pcs_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pcs_pkg::NUM_W-1:0]  num_i,
  input  wire logic [pcs_pkg::DEN_W-1:0]  den_i,
  output logic                            done_o,
  output logic [pcs_pkg::PIX_W-1:0]       quot_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [pcs_pkg::DIV_CW-1:0]   cnt_q;
  logic [pcs_pkg::NUM_W-1:0]    num_q;
  logic [pcs_pkg::DEN_W-1:0]    rem_q, den_q;
  logic [pcs_pkg::DEN_W:0]      trial;
  logic                         ge;

  assign trial = {rem_q, num_q[pcs_pkg::NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? pcs_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[pcs_pkg::DEN_W-1:0];
        num_q <= {num_q[pcs_pkg::NUM_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q[pcs_pkg::PIX_W-1:0];

endmodule

`default_nettype wire

/* design/percentile_contrast_stretch_unit.sv */
// Top level of the percentile contrast stretch unit: sequencer, histogram
// RAM, point tracker and divider. Depends on pcs_pkg, pcs_ram, pcs_point, pcs_div.
//
// Two-pass grey stretch. Histogram words (tuser 0) are counted into a 256-bin
// RAM by read-modify-write while fewer than 4194304 have been seen. The word
// with tlast high also starts the point scan: one bin per cycle over all 256
// bins through the point tracker, zeroing each bin as it goes, then one
// result word with the new points. Mapping words (tuser 1) are clipped or
// go through the 16-step serial divider. After reset the unit zeroes all
// 256 RAM bins before it takes its first word. One result word may wait at
// the output while the next input word is accepted.
`default_nettype none

module percentile_contrast_stretch_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [pcs_pkg::PIX_W-1:0]    s_axis_tdata,  // [7:0] pixel
  input  wire logic                         s_axis_tuser,  // [0] cmd
  input  wire logic                         s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [pcs_pkg::OUT_W-1:0]         m_axis_tdata   // [7:0] mapped_pixel,
                                                           // [16:8] low_point,
                                                           // [25:17] high_point
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HREAD, ST_HWRITE, ST_SCAN, ST_LATCH, ST_MAP, ST_DIV, ST_EMIT
  } state_e;

  state_e                            state_q, state_d;
  logic [pcs_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [pcs_pkg::PIX_W-1:0]         pix_q, pix_d;
  logic                              last_q, last_d;
  logic [pcs_pkg::BIN_W-1:0]         seen_q, seen_d;
  logic signed [pcs_pkg::PT_W-1:0]   thr_lo_q, thr_lo_d, thr_hi_q, thr_hi_d;
  logic [pcs_pkg::PIX_W-1:0]         res_q, res_d;
  logic                              scan_vld_q, scan_vld_d;
  logic [pcs_pkg::BIN_AW-1:0]        scan_idx_q, scan_idx_d;
  logic                              m_tvalid_q, m_tvalid_d;
  logic [pcs_pkg::OUT_W-1:0]         m_tdata_q, m_tdata_d;

  logic                              ram_we, ram_re;
  logic [pcs_pkg::BIN_AW-1:0]        ram_waddr, ram_raddr;
  logic [pcs_pkg::BIN_W-1:0]         ram_wdata, ram_rdata;

  logic                              pt_start;
  pcs_pkg::point_res_t               pt_res;

  logic                              div_start, div_done;
  logic [pcs_pkg::PIX_W-1:0]         div_quot;

  logic                              s_acc;
  logic signed [pcs_pkg::PT_W:0]     p_ext, lo_ext, hi_ext;
  logic [pcs_pkg::PT_W:0]            span_lo, span_hi;
  logic [pcs_pkg::DEN_W+pcs_pkg::PIX_W-1:0] prod;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;

  assign p_ext   = $signed({2'b00, pix_q});
  assign lo_ext  = {thr_lo_q[pcs_pkg::PT_W-1], thr_lo_q};
  assign hi_ext  = {thr_hi_q[pcs_pkg::PT_W-1], thr_hi_q};
  assign span_lo = p_ext - lo_ext;
  assign span_hi = hi_ext - lo_ext;
  assign prod    = span_lo[pcs_pkg::DEN_W-1:0] * pcs_pkg::STRETCH_GAIN;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q[pcs_pkg::BIN_AW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = pix_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_HREAD: begin
        ram_re = 1'b1;
      end
      ST_HWRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pix_q;
        ram_wdata = ram_rdata + 1'b1;
      end
      ST_SCAN: begin
        ram_re    = ~cnt_q[pcs_pkg::CNT_W-1];
        ram_raddr = cnt_q[pcs_pkg::BIN_AW-1:0];
        ram_we    = scan_vld_q;
        ram_waddr = scan_idx_q;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pix_d      = pix_q;
    last_d     = last_q;
    seen_d     = seen_q;
    thr_lo_d   = thr_lo_q;
    thr_hi_d   = thr_hi_q;
    res_d      = res_q;
    scan_vld_d = 1'b0;
    scan_idx_d = scan_idx_q;
    m_tvalid_d = m_tvalid_q & ~m_axis_tready;
    m_tdata_d  = m_tdata_q;
    pt_start   = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q[pcs_pkg::BIN_AW-1:0] == pcs_pkg::LAST_BIN) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_acc) begin
          pix_d  = s_axis_tdata;
          last_d = s_axis_tlast;
          if (s_axis_tuser == pcs_pkg::CMD_MAP) begin
            state_d = ST_MAP;
          end else if (seen_q < pcs_pkg::MAX_PIXELS) begin
            state_d = ST_HREAD;
          end else if (s_axis_tlast) begin
            state_d  = ST_SCAN;
            cnt_d    = '0;
            pt_start = 1'b1;
          end
        end
      end
      ST_HREAD: begin
        state_d = ST_HWRITE;
      end
      ST_HWRITE: begin
        seen_d = seen_q + 1'b1;
        if (last_q) begin
          state_d  = ST_SCAN;
          cnt_d    = '0;
          pt_start = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!cnt_q[pcs_pkg::CNT_W-1]) begin
          cnt_d      = cnt_q + 1'b1;
          scan_vld_d = 1'b1;
          scan_idx_d = cnt_q[pcs_pkg::BIN_AW-1:0];
        end
        if (scan_vld_q && (scan_idx_q == pcs_pkg::LAST_BIN)) begin
          state_d = ST_LATCH;
        end
      end
      ST_LATCH: begin
        thr_lo_d = pt_res.found_lo ? $signed({1'b0, pt_res.pt_lo}) : pcs_pkg::PT_NONE;
        thr_hi_d = pt_res.found_hi ? $signed({1'b0, pt_res.pt_hi}) : pcs_pkg::PT_NONE;
        seen_d   = '0;
        res_d    = '0;
        state_d  = ST_EMIT;
      end
      ST_MAP: begin
        if (p_ext < lo_ext) begin
          res_d   = '0;
          state_d = ST_EMIT;
        end else if (p_ext >= hi_ext) begin
          res_d   = pcs_pkg::PIX_MAX;
          state_d = ST_EMIT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d   = div_quot + 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {6'b0, thr_hi_q, thr_lo_q, res_q};
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      pix_q      <= '0;
      last_q     <= 1'b0;
      seen_q     <= '0;
      thr_lo_q   <= pcs_pkg::PT_LO_RESET;
      thr_hi_q   <= pcs_pkg::PT_HI_RESET;
      res_q      <= '0;
      scan_vld_q <= 1'b0;
      scan_idx_q <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pix_q      <= pix_d;
      last_q     <= last_d;
      seen_q     <= seen_d;
      thr_lo_q   <= thr_lo_d;
      thr_hi_q   <= thr_hi_d;
      res_q      <= res_d;
      scan_vld_q <= scan_vld_d;
      scan_idx_q <= scan_idx_d;
      m_tvalid_q <= m_tvalid_d;
      m_tdata_q  <= m_tdata_d;
    end
  end

  pcs_ram #(
    .WIDTH (pcs_pkg::BIN_W),
    .DEPTH (pcs_pkg::GREY_LEVELS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pcs_point u_point (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pt_start),
    .seen_i    (seen_q),
    .bin_vld_i (scan_vld_q),
    .bin_idx_i (scan_idx_q),
    .bin_cnt_i (ram_rdata),
    .res_o     (pt_res)
  );

  pcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod[pcs_pkg::NUM_W-1:0]),
    .den_i   (span_hi[pcs_pkg::DEN_W-1:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

`default_nettype wire
